[sv/bitmap_block_allocator_macros.svh]
// ----------------------------------------------------------------------------
// bitmap_block_allocator_macros.svh
// assertion macros shared by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, clocked and reset-qualified
`define BBA_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked and reset-qualified
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// widths, codes and state encoding of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  // field widths
  localparam int unsigned FuncW      = 2;
  localparam int unsigned BlockW     = 20;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CountW     = 32;
  localparam int unsigned DataStartW = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;

  // bitmap word layout
  localparam int unsigned WordW = 64;
  localparam int unsigned BitW  = 6;

  // default bitmap size in blocks
  localparam int unsigned BitmapBitsDef = 4096;

  // operation codes
  typedef enum logic [FuncW-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_MARK  = 2'd2
  } func_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DATA_START   = 2'd0,
    CFG_INITIAL_FREE = 2'd1
  } cfg_idx_e;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MODIFY,
    S_RESP
  } state_e;

endpackage

[sv/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit block allocator over a usage bitmap held in a word ram
// ----------------------------------------------------------------------------
// Requests enter on the in channel (func_i, block_number_i, valid/ready) and
// one result word leaves on the out channel (status_o, allocated_block_o,
// free_count_o, valid/ready) for every request. Configuration writes use the
// cfg channel (cfg_index_i, cfg_data_i), which is always ready.
// The bitmap lives in a ram of ceil(BITMAP_BITS/64) 64-bit words with a
// registered read. An allocate scans one word per cycle from word zero
// until it finds a clear bit or reaches the last word; the word scan sets
// the rate. Free and mark read the word, then write it back; a rejected
// request passes through a response step. The result word is registered
// and valid from the edge that ends the request. A new request is taken
// while an earlier result still waits. After reset the ram is swept to
// zero, one word per cycle, over all ceil(BITMAP_BITS/64) words, during
// which no request is taken.
// If the receiver stalls, a finished request holds in its last step until
// the output register frees up.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator #(
  parameter int unsigned BITMAP_BITS = bba_pkg::BitmapBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bba_pkg::FuncW-1:0]     func_i,
  input  logic [bba_pkg::BlockW-1:0]    block_number_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bba_pkg::StatusW-1:0]   status_o,
  output logic [bba_pkg::BlockW-1:0]    allocated_block_o,
  output logic [bba_pkg::CountW-1:0]    free_count_o,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bba_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bba_pkg::CfgDataW-1:0]  cfg_data_i
);

  import bba_pkg::*;

  localparam int unsigned MapWords = (BITMAP_BITS + WordW - 1) / WordW;
  localparam int unsigned AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned IdxW     = AddrW + BitW;
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(MapWords - 1);
  localparam logic [BlockW-1:0] MapLimit = BlockW'(BITMAP_BITS);

  // state and registers
  state_e                 state_q, state_d;
  logic [AddrW-1:0]       addr_q, addr_d;
  logic [BitW-1:0]        bit_q, bit_d;
  logic                   set_q, set_d;
  logic [DataStartW-1:0]  data_start_q;
  logic [CountW-1:0]      cnt_q, cnt_d, cnt_next;
  logic                   out_valid_q, out_valid_d;
  logic [StatusW-1:0]     status_q, status_d;
  logic [BlockW-1:0]      alloc_q, alloc_d;
  logic [CountW-1:0]      free_count_q;
  logic                   out_load;

  // ram port signals
  logic                   ram_we, ram_re;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [WordW-1:0]       ram_wdata, ram_rdata;

  // request decode
  logic                   in_acc, out_free, cfg_we;
  logic                   req_ok;
  logic [BlockW-1:0]      req_off, free_off;

  // scan evaluation
  logic                   scan_full_word, scan_last, scan_done, scan_hit;
  logic [BitW-1:0]        zpos;
  logic [IdxW-1:0]        scan_idx;
  logic [WordW-1:0]       bit_mask, zpos_mask;

  bba_ram #(
    .Width (WordW),
    .Depth (MapWords)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshakes
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // range check and bitmap offset of a free or mark request
  assign free_off = block_number_i - BlockW'(data_start_q);
  always_comb begin
    req_ok  = 1'b0;
    req_off = block_number_i;
    unique case (func_i)
      FUNC_FREE: begin
        req_off = free_off;
        req_ok  = (block_number_i >= BlockW'(data_start_q)) && (free_off < MapLimit);
      end
      FUNC_MARK: begin
        req_ok = (block_number_i < MapLimit);
      end
      default: begin
        req_ok = 1'b0;
      end
    endcase
  end

  // lowest clear bit of the word under scan
  always_comb begin
    zpos = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!ram_rdata[i]) begin
        zpos = BitW'(i);
      end
    end
  end

  assign scan_full_word = &ram_rdata;
  assign scan_last      = (addr_q == LastAddr);
  assign scan_done      = !scan_full_word || scan_last;
  assign scan_idx       = {addr_q, zpos};
  assign scan_hit       = !scan_full_word && (BlockW'(scan_idx) < MapLimit);
  assign zpos_mask      = WordW'(1) << zpos;
  assign bit_mask       = WordW'(1) << bit_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (scan_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (func_i == FUNC_ALLOC) state_d = S_SCAN;
          else if (req_ok)          state_d = S_MODIFY;
          else                      state_d = S_RESP;
        end
      end
      S_SCAN: begin
        if (scan_done && out_free) state_d = S_IDLE;
      end
      S_MODIFY, S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // ram control, scan address and result generation
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = addr_q;
    addr_d    = addr_q;
    bit_d     = bit_q;
    set_d     = set_q;
    out_load  = 1'b0;
    status_d  = STAT_OK;
    alloc_d   = '0;
    cnt_next  = cnt_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        addr_d = addr_q + AddrW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          if (func_i == FUNC_ALLOC) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            addr_d    = '0;
          end else if (req_ok) begin
            ram_re    = 1'b1;
            ram_raddr = req_off[IdxW-1:BitW];
            addr_d    = req_off[IdxW-1:BitW];
            bit_d     = req_off[BitW-1:0];
            set_d     = (func_i == FUNC_MARK);
          end
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          ram_re    = 1'b1;
          ram_raddr = addr_q + AddrW'(1);
          addr_d    = addr_q + AddrW'(1);
        end else if (out_free) begin
          out_load = 1'b1;
          if (scan_hit) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | zpos_mask;
            alloc_d   = BlockW'(scan_idx) + BlockW'(data_start_q);
            if (cnt_q != '0) cnt_next = cnt_q - CountW'(1);
          end else begin
            status_d = STAT_FULL;
          end
        end
      end
      S_MODIFY: begin
        if (out_free) begin
          out_load  = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = set_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
          if (!set_q && (cnt_q != '1)) cnt_next = cnt_q + CountW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          status_d = STAT_RANGE;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // free counter, loaded by a configuration write
  assign cnt_d = (cfg_we && (cfg_index_i == CFG_INITIAL_FREE)) ? cfg_data_i : cnt_next;

  // output valid
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      addr_q       <= '0;
      set_q        <= 1'b0;
      bit_q        <= '0;
      data_start_q <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      set_q       <= set_d;
      bit_q       <= bit_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we && (cfg_index_i == CFG_DATA_START)) begin
        data_start_q <= cfg_data_i[DataStartW-1:0];
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q     <= status_d;
      alloc_q      <= alloc_d;
      free_count_q <= cnt_next;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign allocated_block_o = alloc_q;
  assign free_count_o      = free_count_q;

  // assertions
  `BBA_ASSERT(a_no_write_when_ready, clk_i, rst_ni, ram_we, !in_ready_o,
              "bitmap write while a request can be accepted")
  `BBA_ASSERT(a_scan_in_map, clk_i, rst_ni, state_q == S_SCAN, addr_q <= LastAddr,
              "scan address past the last bitmap word")
  `BBA_ASSERT_NEXT(a_full_keeps_count, clk_i, rst_ni,
                   out_load && (status_d == STAT_FULL) && !cfg_we,
                   cnt_q == $past(cnt_q),
                   "full result changed the free counter")
  `BBA_ASSERT(a_load_needs_slot, clk_i, rst_ni, out_load, out_free,
              "result loaded over an untaken result")

endmodule
